// ===== rtl/ssd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Shared widths and latencies of the segment distance pipeline.
package ssd_pkg;

  // Coordinate and difference widths.
  localparam int COORD_W = 32;
  localparam int DIFF_W  = 33;
  // Single products and dot products of difference vectors.
  localparam int PROD_W  = 66;
  localparam int DOT_W   = 68;
  // Half of a dot product operand, as cut by the wide multiplier.
  localparam int HALF_W  = DOT_W / 2;
  // Products of dot products, numerators, denominators and squared length.
  localparam int WIDE_W  = 136;
  // Parameter fraction, unsigned Q1.32.
  localparam int FRAC_BITS = 32;
  localparam int FRAC_W    = FRAC_BITS + 1;
  // Scaled parameter times a difference component.
  localparam int SCL_W = FRAC_W + 1 + DIFF_W;
  // Square root iterations: one result bit per stage.
  localparam int ROOT_STEPS = WIDE_W / 2;
  localparam int DIST_W     = 32;

  // Latencies of the pipeline parts.
  localparam int MUL_LAT  = 2;
  localparam int DIV_LAT  = FRAC_BITS + 1;
  localparam int ROOT_LAT = ROOT_STEPS;
  // Stage that holds the divider results, and the whole depth.
  localparam int DIV_DONE = 8 + DIV_LAT;
  localparam int LAT      = DIV_DONE + 5 + ROOT_LAT + 1;
  // Delay of the difference vectors from the first stage to the divider output.
  localparam int UVW_DLY  = DIV_DONE - 1;

  // Outcome of the divider range check.
  typedef enum logic [2:0] {
    FRAC_ZERO = 3'b001,
    FRAC_ONE  = 3'b010,
    FRAC_DIV  = 3'b100
  } frac_mode_t;

endpackage
`default_nettype wire

// ===== rtl/ssd_mul.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Signed 68 by 68 multiplier, cut into four partial products over two stages.
module ssd_mul import ssd_pkg::*; (
  input  wire logic                     clk,
  input  wire logic                     en,
  input  wire logic signed [DOT_W-1:0]  a,
  input  wire logic signed [DOT_W-1:0]  b,
  output logic signed [WIDE_W-1:0]      p
);

  logic signed [HALF_W:0]     al, bl;
  logic signed [HALF_W-1:0]   ah, bh;
  logic signed [2*HALF_W+1:0] ll, lh, hl, hh;

  // Low halves are unsigned, high halves carry the sign.
  assign al = $signed({1'b0, a[HALF_W-1:0]});
  assign bl = $signed({1'b0, b[HALF_W-1:0]});
  assign ah = a[DOT_W-1:HALF_W];
  assign bh = b[DOT_W-1:HALF_W];

  // First stage: partial products.
  always_ff @(posedge clk) begin
    if (en) begin
      ll <= al * bl;
      lh <= al * bh;
      hl <= ah * bl;
      hh <= ah * bh;
    end
  end

  // Second stage: weighted sum.
  always_ff @(posedge clk) begin
    if (en) begin
      p <= WIDE_W'(ll) + (WIDE_W'(lh) <<< HALF_W) + (WIDE_W'(hl) <<< HALF_W)
           + (WIDE_W'(hh) <<< (2 * HALF_W));
    end
  end

endmodule
`default_nettype wire

// ===== rtl/ssd_frac.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Fraction num/den as Q1.32: a range check stage, then one quotient bit per stage.
module ssd_frac import ssd_pkg::*; (
  input  wire logic                     clk,
  input  wire logic                     en,
  input  wire logic signed [WIDE_W-1:0] num,
  input  wire logic signed [WIDE_W-1:0] den,
  output logic [FRAC_W-1:0]             q
);

  frac_mode_t        mode [FRAC_BITS+1];
  logic [WIDE_W-1:0] rem  [FRAC_BITS+1];
  logic [WIDE_W-1:0] dvs  [FRAC_BITS+1];
  logic [FRAC_W-1:0] quo  [FRAC_BITS+1];

  // Range check: zero or negative operands give zero, num at or above den gives one.
  always_ff @(posedge clk) begin
    if (en) begin
      if (num <= 0 || den <= 0) begin
        mode[0] <= FRAC_ZERO;
      end else if (num >= den) begin
        mode[0] <= FRAC_ONE;
      end else begin
        mode[0] <= FRAC_DIV;
      end
      rem[0] <= num;
      dvs[0] <= den;
      quo[0] <= '0;
    end
  end

  // Restoring division, one bit per stage.
  for (genvar k = 0; k < FRAC_BITS; k++) begin : g_step
    logic [WIDE_W:0] shl;
    logic [WIDE_W:0] dif;
    assign shl = {rem[k], 1'b0};
    assign dif = shl - {1'b0, dvs[k]};
    always_ff @(posedge clk) begin
      if (en) begin
        mode[k+1] <= mode[k];
        dvs[k+1]  <= dvs[k];
        if (shl >= {1'b0, dvs[k]}) begin
          rem[k+1] <= dif[WIDE_W-1:0];
          quo[k+1] <= {quo[k][FRAC_W-2:0], 1'b1};
        end else begin
          rem[k+1] <= shl[WIDE_W-1:0];
          quo[k+1] <= {quo[k][FRAC_W-2:0], 1'b0};
        end
      end
    end
  end

  // Select the result by the range check.
  always_comb begin
    unique case (mode[FRAC_BITS])
      FRAC_ZERO: q = '0;
      FRAC_ONE:  q = FRAC_W'(1) << FRAC_BITS;
      FRAC_DIV:  q = quo[FRAC_BITS];
      default:   q = '0;
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/ssd_sqrt.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Integer square root, one result bit per register stage.
module ssd_sqrt import ssd_pkg::*; (
  input  wire logic              clk,
  input  wire logic              en,
  input  wire logic [WIDE_W-1:0] x,
  output logic [WIDE_W-1:0]      root
);

  logic [WIDE_W-1:0] rad [ROOT_STEPS+1];
  logic [WIDE_W-1:0] res [ROOT_STEPS+1];

  assign rad[0]  = x;
  assign res[0]  = '0;
  assign root    = res[ROOT_STEPS];

  // Each stage tries one bit, from the highest power of four down.
  for (genvar k = 0; k < ROOT_STEPS; k++) begin : g_step
    localparam logic [WIDE_W-1:0] BIT = WIDE_W'(1) << (WIDE_W - 2 - 2 * k);
    logic [WIDE_W-1:0] trial;
    assign trial = res[k] + BIT;
    always_ff @(posedge clk) begin
      if (en) begin
        if (rad[k] >= trial) begin
          rad[k+1] <= rad[k] - trial;
          res[k+1] <= (res[k] >> 1) + BIT;
        end else begin
          rad[k+1] <= rad[k];
          res[k+1] <= res[k] >> 1;
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/segment_segment_distance_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Channel   Handshake            Payload
// input     in_valid, in_stall   seg_a_start/end_x/y/z, seg_b_start/end_x/y/z
// output    out_valid, out_stall distance
//
// One word enters per cycle while the output is not stalled.
// The depth comes from the 33-stage fraction dividers and the 68-stage root.
// Reset clears only the stage valid bits; the datapath carries no reset.
// A stalled output word freezes the whole pipeline, and the input stalls with it.
module segment_segment_distance_unit import ssd_pkg::*; (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic signed [COORD_W-1:0] seg_a_start_x,
  input  wire logic signed [COORD_W-1:0] seg_a_start_y,
  input  wire logic signed [COORD_W-1:0] seg_a_start_z,
  input  wire logic signed [COORD_W-1:0] seg_a_end_x,
  input  wire logic signed [COORD_W-1:0] seg_a_end_y,
  input  wire logic signed [COORD_W-1:0] seg_a_end_z,
  input  wire logic signed [COORD_W-1:0] seg_b_start_x,
  input  wire logic signed [COORD_W-1:0] seg_b_start_y,
  input  wire logic signed [COORD_W-1:0] seg_b_start_z,
  input  wire logic signed [COORD_W-1:0] seg_b_end_x,
  input  wire logic signed [COORD_W-1:0] seg_b_end_y,
  input  wire logic signed [COORD_W-1:0] seg_b_end_z,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic [DIST_W-1:0]              distance
);

  logic en;
  logic [LAT-1:0] vld;

  logic signed [COORD_W-1:0] a0 [3], a1 [3], b0 [3], b1 [3];
  logic signed [DIFF_W-1:0]  u [3], v [3], w [3];
  logic signed [DIFF_W-1:0]  u_d [UVW_DLY][3];
  logic signed [DIFF_W-1:0]  v_d [UVW_DLY][3];
  logic signed [DIFF_W-1:0]  w_d [UVW_DLY][3];
  logic signed [PROD_W-1:0]  p_uu [3], p_uv [3], p_vv [3], p_uw [3], p_vw [3];
  logic signed [DOT_W-1:0]   da, db, dc, dd, de;
  logic signed [DOT_W-1:0]   da_d [MUL_LAT], db_d [MUL_LAT], dc_d [MUL_LAT];
  logic signed [DOT_W-1:0]   dd_d [MUL_LAT], de_d [MUL_LAT];
  logic signed [WIDE_W-1:0]  m_ac, m_bb, m_be, m_cd, m_ae, m_bd;
  logic signed [WIDE_W-1:0]  den, sn0, tn0;
  logic signed [DOT_W-1:0]   a6, b6, c6, d6, e6;
  logic signed [WIDE_W-1:0]  sn1, sd1, tn1, td1;
  logic signed [WIDE_W-1:0]  sn1_next, sd1_next, tn1_next, td1_next;
  logic signed [DOT_W-1:0]   a7, b7, d7;
  logic signed [WIDE_W-1:0]  sn2, sd2, tn2, td2;
  logic signed [WIDE_W-1:0]  sn2_next, sd2_next, tn2_next;
  logic signed [WIDE_W-1:0]  a7w, d7w, bd7;
  logic [FRAC_W-1:0]         sc, tc;
  logic signed [SCL_W-1:0]   su [3], tv [3];
  logic signed [DIFF_W-1:0]  w42 [3];
  logic signed [DOT_W-1:0]   pd [3];
  logic signed [WIDE_W-1:0]  sq [3];
  logic [WIDE_W-1:0]         len2;
  logic [WIDE_W-1:0]         root;

  // The pipeline moves unless a finished word is held at the output.
  assign en        = !(vld[LAT-1] && out_stall);
  assign in_stall  = !en;
  assign out_valid = vld[LAT-1];

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], in_valid};
    end
  end

  assign a0 = '{seg_a_start_x, seg_a_start_y, seg_a_start_z};
  assign a1 = '{seg_a_end_x, seg_a_end_y, seg_a_end_z};
  assign b0 = '{seg_b_start_x, seg_b_start_y, seg_b_start_z};
  assign b1 = '{seg_b_end_x, seg_b_end_y, seg_b_end_z};

  // Difference vectors and their fifteen component products.
  for (genvar k = 0; k < 3; k++) begin : g_vec
    always_ff @(posedge clk) begin
      if (en) begin
        u[k]    <= DIFF_W'(a1[k]) - DIFF_W'(a0[k]);
        v[k]    <= DIFF_W'(b1[k]) - DIFF_W'(b0[k]);
        w[k]    <= DIFF_W'(a0[k]) - DIFF_W'(b0[k]);
        p_uu[k] <= u[k] * u[k];
        p_uv[k] <= u[k] * v[k];
        p_vv[k] <= v[k] * v[k];
        p_uw[k] <= u[k] * w[k];
        p_vw[k] <= v[k] * w[k];
        u_d[0][k] <= u[k];
        v_d[0][k] <= v[k];
        w_d[0][k] <= w[k];
      end
    end
    for (genvar j = 1; j < UVW_DLY; j++) begin : g_dly
      always_ff @(posedge clk) begin
        if (en) begin
          u_d[j][k] <= u_d[j-1][k];
          v_d[j][k] <= v_d[j-1][k];
          w_d[j][k] <= w_d[j-1][k];
        end
      end
    end
  end

  // Dot products a, b, c, d, e.
  always_ff @(posedge clk) begin
    if (en) begin
      da <= DOT_W'(p_uu[0]) + DOT_W'(p_uu[1]) + DOT_W'(p_uu[2]);
      db <= DOT_W'(p_uv[0]) + DOT_W'(p_uv[1]) + DOT_W'(p_uv[2]);
      dc <= DOT_W'(p_vv[0]) + DOT_W'(p_vv[1]) + DOT_W'(p_vv[2]);
      dd <= DOT_W'(p_uw[0]) + DOT_W'(p_uw[1]) + DOT_W'(p_uw[2]);
      de <= DOT_W'(p_vw[0]) + DOT_W'(p_vw[1]) + DOT_W'(p_vw[2]);
      da_d[0] <= da;
      db_d[0] <= db;
      dc_d[0] <= dc;
      dd_d[0] <= dd;
      de_d[0] <= de;
      for (int i = 1; i < MUL_LAT; i++) begin
        da_d[i] <= da_d[i-1];
        db_d[i] <= db_d[i-1];
        dc_d[i] <= dc_d[i-1];
        dd_d[i] <= dd_d[i-1];
        de_d[i] <= de_d[i-1];
      end
    end
  end

  // Products of dot products.
  ssd_mul u_mul_ac (.clk, .en, .a(da), .b(dc), .p(m_ac));
  ssd_mul u_mul_bb (.clk, .en, .a(db), .b(db), .p(m_bb));
  ssd_mul u_mul_be (.clk, .en, .a(db), .b(de), .p(m_be));
  ssd_mul u_mul_cd (.clk, .en, .a(dc), .b(dd), .p(m_cd));
  ssd_mul u_mul_ae (.clk, .en, .a(da), .b(de), .p(m_ae));
  ssd_mul u_mul_bd (.clk, .en, .a(db), .b(dd), .p(m_bd));

  // Denominator and unclamped numerators.
  always_ff @(posedge clk) begin
    if (en) begin
      den <= m_ac - m_bb;
      sn0 <= m_be - m_cd;
      tn0 <= m_ae - m_bd;
      a6  <= da_d[MUL_LAT-1];
      b6  <= db_d[MUL_LAT-1];
      c6  <= dc_d[MUL_LAT-1];
      d6  <= dd_d[MUL_LAT-1];
      e6  <= de_d[MUL_LAT-1];
    end
  end

  // Parallel case and clamping of the s numerator.
  always_comb begin
    if (den <= 0) begin
      sn1_next = '0;
      sd1_next = WIDE_W'(1);
      tn1_next = WIDE_W'(e6);
      td1_next = WIDE_W'(c6);
    end else if (sn0 < 0) begin
      sn1_next = '0;
      sd1_next = den;
      tn1_next = WIDE_W'(e6);
      td1_next = WIDE_W'(c6);
    end else if (sn0 > den) begin
      sn1_next = den;
      sd1_next = den;
      tn1_next = WIDE_W'(e6) + WIDE_W'(b6);
      td1_next = WIDE_W'(c6);
    end else begin
      sn1_next = sn0;
      sd1_next = den;
      tn1_next = tn0;
      td1_next = den;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sn1 <= sn1_next;
      sd1 <= sd1_next;
      tn1 <= tn1_next;
      td1 <= td1_next;
      a7  <= a6;
      b7  <= b6;
      d7  <= d6;
    end
  end

  // Clamping of the t numerator, which recomputes and clamps s for the clamped t.
  assign a7w = WIDE_W'(a7);
  assign d7w = WIDE_W'(d7);
  assign bd7 = WIDE_W'(b7) - d7w;

  always_comb begin
    sn2_next = sn1;
    sd2_next = sd1;
    tn2_next = tn1;
    if (tn1 < 0) begin
      tn2_next = '0;
      if (d7w >= 0) begin
        sn2_next = '0;
      end else if (-d7w > a7w) begin
        sn2_next = sd1;
      end else begin
        sn2_next = -d7w;
        sd2_next = a7w;
      end
    end else if (tn1 > td1) begin
      tn2_next = td1;
      if (bd7 < 0) begin
        sn2_next = '0;
      end else if (bd7 > a7w) begin
        sn2_next = sd1;
      end else begin
        sn2_next = bd7;
        sd2_next = a7w;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sn2 <= sn2_next;
      sd2 <= sd2_next;
      tn2 <= tn2_next;
      td2 <= td1;
    end
  end

  // Closest-point parameters.
  ssd_frac u_frac_s (.clk, .en, .num(sn2), .den(sd2), .q(sc));
  ssd_frac u_frac_t (.clk, .en, .num(tn2), .den(td2), .q(tc));

  // Closest difference w + s*u - t*v per component.
  for (genvar k = 0; k < 3; k++) begin : g_diff
    always_ff @(posedge clk) begin
      if (en) begin
        su[k]  <= $signed({1'b0, sc}) * u_d[UVW_DLY-1][k];
        tv[k]  <= $signed({1'b0, tc}) * v_d[UVW_DLY-1][k];
        w42[k] <= w_d[UVW_DLY-1][k];
        pd[k]  <= (DOT_W'(w42[k]) <<< FRAC_BITS) + DOT_W'(su[k]) - DOT_W'(tv[k]);
      end
    end
    ssd_mul u_mul_sq (.clk, .en, .a(pd[k]), .b(pd[k]), .p(sq[k]));
  end

  // Squared length.
  always_ff @(posedge clk) begin
    if (en) begin
      len2 <= sq[0] + sq[1] + sq[2];
    end
  end

  ssd_sqrt u_sqrt (.clk, .en, .x(len2), .root(root));

  // Output word, saturated when the root does not fit unsigned Q32.0.
  always_ff @(posedge clk) begin
    if (en) begin
      if (|root[WIDE_W-1:2*DIST_W]) begin
        distance <= '1;
      end else begin
        distance <= root[2*DIST_W-1:DIST_W];
      end
    end
  end

endmodule
`default_nettype wire
